>>> src/flvd_pkg.sv
// Package for the FLV elementary stream demultiplexer.
// Holds parse phase codes, result types and ADTS header helpers; no dependencies.
package flvd_pkg;

   typedef enum logic [4:0] {
      PH_FHDR  = 5'd0,
      PH_FSKIP = 5'd1,
      PH_PREV  = 5'd2,
      PH_THDR  = 5'd3,
      PH_BODY0 = 5'd4,
      PH_SKIP  = 5'd5,
      PH_VPKT  = 5'd6,
      PH_VCFG  = 5'd7,
      PH_SPS   = 5'd8,
      PH_NPPS  = 5'd9,
      PH_PPSL  = 5'd10,
      PH_PPS   = 5'd11,
      PH_VCT   = 5'd12,
      PH_NLEN  = 5'd13,
      PH_NAL   = 5'd14,
      PH_APKT  = 5'd15,
      PH_ACFG  = 5'd16,
      PH_ARAW  = 5'd17
   } phase_type;

   typedef enum logic [1:0] {
      EMIT_NONE  = 2'd0,
      EMIT_BYTE  = 2'd1,
      EMIT_START = 2'd2,
      EMIT_ADTS  = 2'd3
   } emit_type;

   localparam logic [7:0] TAG_VIDEO = 8'h09;
   localparam logic [7:0] TAG_AUDIO = 8'h08;
   localparam logic [3:0] CODEC_AVC = 4'd7;
   localparam logic [3:0] FMT_AAC   = 4'd10;

   typedef struct packed {
      emit_type   kind;
      logic [7:0] data;
      logic       stream;
      logic [1:0] profile;
      logic [3:0] rate_index;
      logic [2:0] channels;
      logic [12:0] frame_len;
   } emit_req_type;

   function automatic logic [7:0] adts_byte(input logic [2:0] idx, input emit_req_type e);
      logic [7:0] r;
      begin
         case (idx)
            3'd0: r = 8'hFF;
            3'd1: r = 8'hF1;
            3'd2: r = {e.profile, e.rate_index, 1'b0, e.channels[2]};
            3'd3: r = {e.channels[1:0], 4'b0000, e.frame_len[12:11]};
            3'd4: r = e.frame_len[10:3];
            3'd5: r = {e.frame_len[2:0], 5'h1F};
            3'd6: r = 8'hFC;
            default: r = 8'h00;
         endcase
         adts_byte = r;
      end
   endfunction

endpackage

>>> src/flvd_emitter.sv
// Result serializer: expands one request's emit code into 1, 4 or 7 result bytes.
// Holds a two-entry queue so a new request is taken while results drain; uses flvd_pkg.
module flvd_emitter
   import flvd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  emit_req_type push_req,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_out_stream,
   output logic         rsp_unit_start,
   output logic         rsp_last
);

   emit_req_type q_ff [2];
   emit_req_type q_in [2];
   logic [1:0]   cnt_ff, cnt_in;
   logic [2:0]   pos_ff, pos_in;
   logic [2:0]   last_pos;
   logic         pop_item;

   always_comb begin
      case (q_ff[0].kind)
         EMIT_START: last_pos = 3'd3;
         EMIT_ADTS:  last_pos = 3'd6;
         default:    last_pos = 3'd0;
      endcase
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign full = (cnt_ff == 2'd2) && !(pop_item);
   assign rsp_last = (pos_ff == last_pos);
   assign rsp_out_stream = q_ff[0].stream;
   assign rsp_unit_start = (pos_ff == 3'd0) && (q_ff[0].kind != EMIT_BYTE);
   assign pop_item = rsp_valid && !rsp_stall && rsp_last;

   always_comb begin
      case (q_ff[0].kind)
         EMIT_START: rsp_out_byte = (pos_ff == 3'd3) ? 8'h01 : 8'h00;
         EMIT_ADTS:  rsp_out_byte = adts_byte(pos_ff, q_ff[0]);
         default:    rsp_out_byte = q_ff[0].data;
      endcase
   end

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (rsp_valid && !rsp_stall) begin
         pos_in = rsp_last ? 3'd0 : pos_ff + 3'd1;
      end
      if (pop_item) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_ff - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) begin
            q_in[0] = push_req;
         end else begin
            q_in[1] = push_req;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
         pos_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff <= last_pos)) else $error("result position overrun");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overrun");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");

endmodule

>>> src/flv_av_elementary_demux_unit.sv
// FLV to H.264 Annex B / AAC ADTS demultiplexer, top level.
// A request's results are registered into the output queue on acceptance.
// One request per cycle while req_stall is low; a start code expands to 4 result bytes and
// an ADTS header to 7, so the input stalls while the two-entry output queue is full.
// Reset is synchronous, active high: parse restarts at the file header.
// Depends on flvd_pkg and flvd_emitter.
module flv_av_elementary_demux_unit
   import flvd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_stream,
   output logic       rsp_unit_start,
   output logic       rsp_last
);

   phase_type    phase_ff, phase_in;
   logic [31:0]  sec_ff, sec_in;
   logic [31:0]  fhs_ff, fhs_in;
   logic [7:0]   kind_ff, kind_in;
   logic [23:0]  tsize_ff, tsize_in;
   logic [23:0]  tcnt_ff, tcnt_in;
   logic [2:0]   nls_ff, nls_in;
   logic [31:0]  nacc_ff, nacc_in;
   logic [31:0]  nrem_ff, nrem_in;
   logic [15:0]  pss_ff, pss_in;
   logic [1:0]   prof_ff, prof_in;
   logic [3:0]   rate_ff, rate_in;
   logic [2:0]   chan_ff, chan_in;
   logic [7:0]   afb_ff, afb_in;
   logic         full;
   logic         take;
   emit_req_type er;
   logic [31:0]  sec_p1;
   logic [23:0]  tcnt_p1;
   logic [31:0]  nacc_sh;
   logic [12:0]  flen;
   logic [7:0]   b;

   assign b = req_in_byte;
   assign req_stall = full;
   assign take = req_valid && !full;
   assign sec_p1 = sec_ff + 32'd1;
   assign tcnt_p1 = tcnt_ff + 24'd1;
   assign nacc_sh = {nacc_ff[23:0], b};
   assign flen = tsize_ff[12:0] + 13'd5;

   always_comb begin
      phase_in = phase_ff;
      sec_in = sec_ff;
      fhs_in = fhs_ff;
      kind_in = kind_ff;
      tsize_in = tsize_ff;
      tcnt_in = tcnt_ff;
      nls_in = nls_ff;
      nacc_in = nacc_ff;
      nrem_in = nrem_ff;
      pss_in = pss_ff;
      prof_in = prof_ff;
      rate_in = rate_ff;
      chan_in = chan_ff;
      afb_in = afb_ff;
      er.kind = EMIT_NONE;
      er.data = b;
      er.stream = 1'b0;
      er.profile = prof_ff;
      er.rate_index = rate_ff;
      er.channels = chan_ff;
      er.frame_len = flen;
      case (phase_ff)
         PH_FHDR: begin
            if (sec_ff >= 32'd5) begin
               fhs_in = {fhs_ff[23:0], b};
            end
            sec_in = sec_p1;
            if (sec_p1 >= 32'd9) begin
               if (fhs_in <= 32'd9) begin
                  phase_in = PH_PREV;
                  sec_in = '0;
               end else begin
                  phase_in = PH_FSKIP;
               end
            end
         end
         PH_FSKIP: begin
            sec_in = sec_p1;
            if (sec_p1 >= fhs_ff) begin
               phase_in = PH_PREV;
               sec_in = '0;
            end
         end
         PH_PREV: begin
            sec_in = sec_p1;
            if (sec_p1 >= 32'd4) begin
               phase_in = PH_THDR;
               sec_in = '0;
            end
         end
         PH_THDR: begin
            if (sec_ff == 32'd0) begin
               kind_in = b;
            end else if (sec_ff <= 32'd3) begin
               tsize_in = {tsize_ff[15:0], b};
            end
            sec_in = sec_p1;
            if (sec_p1 >= 32'd11) begin
               tcnt_in = '0;
               sec_in = '0;
               phase_in = (tsize_in == 24'd0) ? PH_PREV : PH_BODY0;
            end
         end
         default: begin
            case (phase_ff)
               PH_BODY0: begin
                  if (kind_ff == TAG_VIDEO && b[3:0] == CODEC_AVC) begin
                     phase_in = PH_VPKT;
                  end else if (kind_ff == TAG_AUDIO && b[7:4] == FMT_AAC) begin
                     phase_in = PH_APKT;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_VPKT: begin
                  if (b == 8'd0) begin
                     phase_in = PH_VCFG;
                  end else if (b == 8'd1) begin
                     phase_in = PH_VCT;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_VCFG: begin
                  if (tcnt_ff == 24'd9) begin
                     nls_in = {1'b0, b[1:0]} + 3'd1;
                  end else if (tcnt_ff == 24'd11) begin
                     pss_in = {b, 8'h00};
                  end else if (tcnt_ff == 24'd12) begin
                     pss_in = {pss_ff[15:8], b};
                     er.kind = EMIT_START;
                     sec_in = '0;
                     phase_in = (pss_in == 16'd0) ? PH_NPPS : PH_SPS;
                  end
               end
               PH_SPS, PH_PPS: begin
                  er.kind = EMIT_BYTE;
                  sec_in = sec_p1;
                  if (sec_p1 >= {16'd0, pss_ff}) begin
                     phase_in = (phase_ff == PH_SPS) ? PH_NPPS : PH_SKIP;
                  end
               end
               PH_NPPS: begin
                  sec_in = '0;
                  phase_in = PH_PPSL;
               end
               PH_PPSL: begin
                  if (sec_ff == 32'd0) begin
                     pss_in = {b, 8'h00};
                     sec_in = 32'd1;
                  end else begin
                     pss_in = {pss_ff[15:8], b};
                     er.kind = EMIT_START;
                     sec_in = '0;
                     phase_in = (pss_in == 16'd0) ? PH_SKIP : PH_PPS;
                  end
               end
               PH_VCT: begin
                  if (tcnt_ff >= 24'd4) begin
                     phase_in = PH_NLEN;
                     sec_in = '0;
                     nacc_in = '0;
                  end
               end
               PH_NLEN: begin
                  nacc_in = nacc_sh;
                  sec_in = sec_p1;
                  if (sec_p1 >= {29'd0, nls_ff}) begin
                     er.kind = EMIT_START;
                     nrem_in = nacc_sh;
                     if (nacc_sh == 32'd0) begin
                        sec_in = '0;
                        nacc_in = '0;
                     end else begin
                        phase_in = PH_NAL;
                     end
                  end
               end
               PH_NAL: begin
                  er.kind = EMIT_BYTE;
                  nrem_in = nrem_ff - 32'd1;
                  if (nrem_ff == 32'd1) begin
                     phase_in = PH_NLEN;
                     sec_in = '0;
                     nacc_in = '0;
                  end
               end
               PH_APKT: begin
                  if (b == 8'd0) begin
                     phase_in = PH_ACFG;
                  end else if (b == 8'd1) begin
                     er.kind = EMIT_ADTS;
                     er.stream = 1'b1;
                     phase_in = PH_ARAW;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_ACFG: begin
                  if (tcnt_ff == 24'd2) begin
                     afb_in = b;
                  end else if (tcnt_ff == 24'd3) begin
                     prof_in = afb_ff[4:3] - 2'd1;
                     rate_in = {afb_ff[2:0], b[7]};
                     chan_in = b[5:3];
                     phase_in = PH_SKIP;
                  end
               end
               PH_ARAW: begin
                  er.kind = EMIT_BYTE;
                  er.stream = 1'b1;
               end
               default: begin
               end
            endcase
            tcnt_in = tcnt_p1;
            if (tcnt_p1 >= tsize_ff) begin
               phase_in = PH_PREV;
               sec_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FHDR;
         sec_ff <= '0;
         fhs_ff <= '0;
         kind_ff <= '0;
         tsize_ff <= '0;
         tcnt_ff <= '0;
         nls_ff <= 3'd1;
         nacc_ff <= '0;
         nrem_ff <= '0;
         pss_ff <= '0;
         prof_ff <= '0;
         rate_ff <= '0;
         chan_ff <= '0;
         afb_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         sec_ff <= sec_in;
         fhs_ff <= fhs_in;
         kind_ff <= kind_in;
         tsize_ff <= tsize_in;
         tcnt_ff <= tcnt_in;
         nls_ff <= nls_in;
         nacc_ff <= nacc_in;
         nrem_ff <= nrem_in;
         pss_ff <= pss_in;
         prof_ff <= prof_in;
         rate_ff <= rate_in;
         chan_ff <= chan_in;
         afb_ff <= afb_in;
      end
   end

   flvd_emitter u_emit (
      .clock         (clock),
      .reset         (reset),
      .push          (take && (er.kind != EMIT_NONE)),
      .push_req      (er),
      .full          (full),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_stream(rsp_out_stream),
      .rsp_unit_start(rsp_unit_start),
      .rsp_last      (rsp_last)
   );

   a_nls_range: assert property (@(posedge clock) disable iff (reset)
      nls_ff != 3'd0 && nls_ff <= 3'd4) else $error("bad NAL length size");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(phase_ff)) else $error("phase moved without a request");
   a_nal_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_NAL |-> nrem_ff != 32'd0) else $error("NAL phase with nothing left");

endmodule
